>>> sv/nbm_pkg.sv
// ----------------------------------------------------------------------------
// nbm_pkg: shared types, constants and functions
// Sizes, opcodes, register indexes, saturation and the tanh lookup table of
// the neuron training engine.
// ----------------------------------------------------------------------------
package nbm_pkg;

    // Sizing
    localparam int INPUT_COUNT = 16;
    localparam int TANH_DEPTH  = 256;
    localparam int IDX_W       = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int TI_W        = $clog2(TANH_DEPTH);
    // products of two Q8.16 values need 48 bits, plus growth over the entries
    localparam int ACC_W       = 49 + $clog2(INPUT_COUNT);

    // Opcodes
    localparam logic [2:0] OP_LOAD_ACT  = 3'd0;
    localparam logic [2:0] OP_LOAD_WGT  = 3'd1;
    localparam logic [2:0] OP_FORWARD   = 3'd2;
    localparam logic [2:0] OP_OUT_GRAD  = 3'd3;
    localparam logic [2:0] OP_HID_GRAD  = 3'd4;
    localparam logic [2:0] OP_UPDATE    = 3'd5;

    // Configuration register indexes and reset values
    localparam logic       CFG_LEARNING_RATE = 1'b0;
    localparam logic       CFG_MOMENTUM      = 1'b1;
    localparam logic [15:0] LEARNING_RATE_RST = 16'd9830;
    localparam logic [15:0] MOMENTUM_RST      = 16'd32768;

    // Value types
    typedef logic signed [23:0] q_t;
    typedef logic signed [17:0] out_t;
    typedef logic signed [63:0] wide_t;
    typedef logic signed [32:0] mul_a_t;
    typedef logic signed [24:0] mul_b_t;
    typedef logic signed [57:0] mul_p_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [24+TI_W:0] tscale_t;
    typedef logic [16:0] tanh_rom_t [TANH_DEPTH];

    // Write command into the entry store
    typedef struct packed {
        logic act_we;
        logic wgt_we;
        logic dlt_we;
        idx_t idx;
        q_t   act;
        q_t   wgt;
        q_t   dlt;
    } store_wr_t;

    localparam wide_t Q_MAX_W = 64'sd8388607;
    localparam wide_t Q_MIN_W = -64'sd8388608;

    // Clamp to the 24-bit Q8.16 range
    function automatic q_t sat24(input wide_t x);
        q_t r;
        if (x > Q_MAX_W)
            r = q_t'(Q_MAX_W);
        else if (x < Q_MIN_W)
            r = q_t'(Q_MIN_W);
        else
            r = q_t'(x);
        return r;
    endfunction

    // Unsigned restoring division for table construction, one quotient bit per step
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4*k/TANH_DEPTH) in Q16, built from e^-2x in Q30 at elaboration
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t         rom;
        longint unsigned   z;
        longint unsigned   t;
        longint            sum;
        longint unsigned   e;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   val;
        for (int k = 0; k < TANH_DEPTH; k++)
        begin
            z   = div_u64(64'(k) << 30, 64'(2 * TANH_DEPTH));
            t   = 64'd1 << 30;
            sum = longint'(64'd1 << 30);
            for (int n = 1; n <= 16; n++)
            begin
                t = div_u64((t * z) >> 30, 64'(n));
                if ((n & 1) == 1)
                    sum = sum - longint'(t);
                else
                    sum = sum + longint'(t);
            end
            e = (sum > 0) ? longint'(sum) : 64'd0;
            if (e > (64'd1 << 30))
                e = 64'd1 << 30;
            for (int n = 0; n < 4; n++)
                e = (e * e) >> 30;
            num    = (64'd1 << 30) - e;
            den    = (64'd1 << 30) + e;
            val    = div_u64(num * 64'd131072 + den, 64'd2 * den);
            rom[k] = val[16:0];
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

>>> sv/nbm_mul.sv
// ----------------------------------------------------------------------------
// nbm_mul: shared signed multiplier
// One 33 x 25 signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module nbm_mul
(
    input  logic            clk,
    input  nbm_pkg::mul_a_t a,
    input  nbm_pkg::mul_b_t b,
    output nbm_pkg::mul_p_t prod
);

    nbm_pkg::mul_p_t prod_reg;
    nbm_pkg::mul_p_t prod_next;

    // product, sign extended to full width
    assign prod_next = nbm_pkg::mul_p_t'(a) * nbm_pkg::mul_p_t'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> sv/nbm_store.sv
// ----------------------------------------------------------------------------
// nbm_store: per-entry state
// Activations, weights and previous weight deltas, one read index shared by
// all three, one write command per cycle. Reset clears every entry.
// ----------------------------------------------------------------------------
module nbm_store
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbm_pkg::idx_t        rd_idx,
    input  nbm_pkg::store_wr_t   wr,
    output nbm_pkg::q_t          act_rd,
    output nbm_pkg::q_t          wgt_rd,
    output nbm_pkg::q_t          dlt_rd
);

    nbm_pkg::q_t act_reg [nbm_pkg::INPUT_COUNT];
    nbm_pkg::q_t wgt_reg [nbm_pkg::INPUT_COUNT];
    nbm_pkg::q_t dlt_reg [nbm_pkg::INPUT_COUNT];

    // entry writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nbm_pkg::INPUT_COUNT; i++)
            begin
                act_reg[i] <= '0;
                wgt_reg[i] <= '0;
                dlt_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.act_we)
                act_reg[wr.idx] <= wr.act;
            if (wr.wgt_we)
                wgt_reg[wr.idx] <= wr.wgt;
            if (wr.dlt_we)
                dlt_reg[wr.idx] <= wr.dlt;
        end
    end

    // read port
    assign act_rd = act_reg[rd_idx];
    assign wgt_rd = wgt_reg[rd_idx];
    assign dlt_rd = dlt_reg[rd_idx];

endmodule

>>> sv/nbm_tanh.sv
// ----------------------------------------------------------------------------
// nbm_tanh: tanh activation
// Odd-symmetric table lookup on the magnitude, saturating to one past the
// end of the table.
// ----------------------------------------------------------------------------
module nbm_tanh
(
    input  nbm_pkg::q_t   s,
    output nbm_pkg::out_t y
);

    logic [23:0]       mag;
    nbm_pkg::tscale_t  scaled;
    nbm_pkg::tscale_t  pos;
    logic [16:0]       mag_r;
    nbm_pkg::out_t     r;

    // magnitude; the most negative input maps to 2^23
    assign mag    = s[23] ? 24'(-s) : 24'(s);
    assign scaled = nbm_pkg::tscale_t'(mag) * nbm_pkg::tscale_t'(nbm_pkg::TANH_DEPTH);
    assign pos    = scaled >> 18;

    // lookup, past the table end reads as one
    always_comb
    begin
        if (pos >= nbm_pkg::tscale_t'(nbm_pkg::TANH_DEPTH))
            mag_r = 17'h10000;
        else
            mag_r = nbm_pkg::TANH_ROM[pos[nbm_pkg::TI_W-1:0]];
    end

    assign r = nbm_pkg::out_t'(mag_r);
    assign y = s[23] ? -r : r;

endmodule

>>> sv/neuron_backprop_momentum_core.sv
// ----------------------------------------------------------------------------
// neuron_backprop_momentum_core: single-neuron training engine
// Q8.16 tanh neuron with load, forward, gradient and momentum update opcodes,
// all multiplies through one shared registered multiplier.
// ----------------------------------------------------------------------------
// One item at a time; the shared multiplier sets the pace (one entry per
// cycle in forward, three multiplies per entry in update).
// Reset clears all entries, output and gradient and reloads the registers.
module neuron_backprop_momentum_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [2:0] opcode, [6:3] slot, [30:7] operand_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [17:0] output_value, [41:18] gradient_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EXEC     = 4'd1;
    localparam logic [3:0] ST_FWD      = 4'd2;
    localparam logic [3:0] ST_FWD_LAST = 4'd3;
    localparam logic [3:0] ST_SAT      = 4'd4;
    localparam logic [3:0] ST_TANH     = 4'd5;
    localparam logic [3:0] ST_DER      = 4'd6;
    localparam logic [3:0] ST_DER_D    = 4'd7;
    localparam logic [3:0] ST_GRAD     = 4'd8;
    localparam logic [3:0] ST_GRAD_WB  = 4'd9;
    localparam logic [3:0] ST_UPD_P    = 4'd10;
    localparam logic [3:0] ST_UPD_T2   = 4'd11;
    localparam logic [3:0] ST_UPD_T1   = 4'd12;
    localparam logic [3:0] ST_UPD_WB   = 4'd13;
    localparam logic [3:0] ST_DONE     = 4'd14;

    localparam nbm_pkg::idx_t IDX_LAST = nbm_pkg::idx_t'(nbm_pkg::INPUT_COUNT - 1);

    logic [3:0]            state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [3:0]            slot_reg, slot_next;
    nbm_pkg::q_t           v_reg, v_next;
    nbm_pkg::idx_t         idx_reg, idx_next;
    nbm_pkg::acc_t         acc_reg, acc_next;
    logic                  pend_reg, pend_next;
    nbm_pkg::q_t           s_reg, s_next;
    logic [16:0]           d_reg, d_next;
    logic signed [31:0]    p_reg, p_next;
    logic signed [24:0]    t2_reg, t2_next;
    nbm_pkg::out_t         out_reg, out_next;
    nbm_pkg::q_t           grad_reg, grad_next;
    logic [15:0]           learning_rate_reg;
    logic [15:0]           momentum_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [47:0]           m_tdata_reg, m_tdata_next;

    nbm_pkg::mul_a_t       mul_a;
    nbm_pkg::mul_b_t       mul_b;
    nbm_pkg::mul_p_t       prod;
    nbm_pkg::store_wr_t    wr;
    nbm_pkg::q_t           act_rd, wgt_rd, dlt_rd;
    nbm_pkg::out_t         tanh_y;
    logic                  slot_ok;
    logic signed [33:0]    t1;
    nbm_pkg::q_t           nd;

    // Units
    nbm_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    nbm_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (idx_reg),
        .wr     (wr),
        .act_rd (act_rd),
        .wgt_rd (wgt_rd),
        .dlt_rd (dlt_rd)
    );

    nbm_tanh u_tanh
    (
        .s (s_reg),
        .y (tanh_y)
    );

    // Handshake outputs
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= nbm_pkg::LEARNING_RATE_RST;
            momentum_reg      <= nbm_pkg::MOMENTUM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == nbm_pkg::CFG_LEARNING_RATE)
                learning_rate_reg <= cfg_data;
            else
                momentum_reg <= cfg_data;
        end
    end

    // Update arithmetic for one entry
    assign slot_ok = (32'(slot_reg) < 32'(nbm_pkg::INPUT_COUNT));
    assign t1      = 34'(prod >>> 16);
    assign nd      = nbm_pkg::sat24(nbm_pkg::wide_t'(t1) + nbm_pkg::wide_t'(t2_reg));

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FWD:
            begin
                mul_a = nbm_pkg::mul_a_t'(act_rd);
                mul_b = nbm_pkg::mul_b_t'(wgt_rd);
            end
            ST_DER:
            begin
                mul_a = nbm_pkg::mul_a_t'(out_reg);
                mul_b = nbm_pkg::mul_b_t'(out_reg);
            end
            ST_GRAD:
            begin
                if (op_reg == nbm_pkg::OP_OUT_GRAD)
                    mul_a = nbm_pkg::mul_a_t'(v_reg) - nbm_pkg::mul_a_t'(out_reg);
                else
                    mul_a = nbm_pkg::mul_a_t'(v_reg);
                mul_b = nbm_pkg::mul_b_t'({8'd0, d_reg});
            end
            ST_UPD_P:
            begin
                mul_a = nbm_pkg::mul_a_t'(act_rd);
                mul_b = nbm_pkg::mul_b_t'(grad_reg);
            end
            ST_UPD_T2:
            begin
                mul_a = nbm_pkg::mul_a_t'(dlt_rd);
                mul_b = nbm_pkg::mul_b_t'({9'd0, momentum_reg});
            end
            ST_UPD_T1:
            begin
                mul_a = nbm_pkg::mul_a_t'(p_reg);
                mul_b = nbm_pkg::mul_b_t'({9'd0, learning_rate_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        v_next        = v_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        s_next        = s_reg;
        d_next        = d_reg;
        p_next        = p_reg;
        t2_next       = t2_reg;
        out_next      = out_reg;
        grad_next     = grad_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr            = '0;
        wr.idx        = idx_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[2:0];
                    slot_next  = s_tdata[6:3];
                    v_next     = s_tdata[30:7];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                idx_next = '0;
                case (op_reg)
                    nbm_pkg::OP_LOAD_ACT:
                    begin
                        wr.idx     = nbm_pkg::idx_t'(slot_reg);
                        wr.act     = v_reg;
                        wr.act_we  = slot_ok;
                        state_next = ST_DONE;
                    end
                    nbm_pkg::OP_LOAD_WGT:
                    begin
                        wr.idx     = nbm_pkg::idx_t'(slot_reg);
                        wr.wgt     = v_reg;
                        wr.wgt_we  = slot_ok;
                        state_next = ST_DONE;
                    end
                    nbm_pkg::OP_FORWARD:
                    begin
                        acc_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_FWD;
                    end
                    nbm_pkg::OP_OUT_GRAD, nbm_pkg::OP_HID_GRAD:
                        state_next = ST_DER;
                    nbm_pkg::OP_UPDATE:
                        state_next = ST_UPD_P;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            // one product issued per cycle, accumulated in the next cycle
            ST_FWD:
            begin
                if (pend_reg)
                    acc_next = acc_reg + nbm_pkg::acc_t'(prod);
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                    state_next = ST_FWD_LAST;
            end
            ST_FWD_LAST:
            begin
                acc_next   = acc_reg + nbm_pkg::acc_t'(prod);
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                s_next     = nbm_pkg::sat24(nbm_pkg::wide_t'(acc_reg >>> 16));
                state_next = ST_TANH;
            end
            ST_TANH:
            begin
                out_next   = tanh_y;
                state_next = ST_DONE;
            end
            // derivative 1 - o^2
            ST_DER:
                state_next = ST_DER_D;
            ST_DER_D:
            begin
                d_next     = 17'h10000 - prod[32:16];
                state_next = ST_GRAD;
            end
            ST_GRAD:
                state_next = ST_GRAD_WB;
            ST_GRAD_WB:
            begin
                grad_next  = nbm_pkg::sat24(nbm_pkg::wide_t'(prod >>> 16));
                state_next = ST_DONE;
            end
            // momentum update, three multiplies per entry
            ST_UPD_P:
                state_next = ST_UPD_T2;
            ST_UPD_T2:
            begin
                p_next     = 32'(prod >>> 16);
                state_next = ST_UPD_T1;
            end
            ST_UPD_T1:
            begin
                t2_next    = 25'(prod >>> 16);
                state_next = ST_UPD_WB;
            end
            ST_UPD_WB:
            begin
                wr.dlt_we = 1'b1;
                wr.dlt    = nd;
                wr.wgt_we = 1'b1;
                wr.wgt    = nbm_pkg::sat24(nbm_pkg::wide_t'(wgt_rd) + nbm_pkg::wide_t'(nd));
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                    state_next = ST_DONE;
                else
                    state_next = ST_UPD_P;
            end
            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, grad_reg, out_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            out_reg      <= '0;
            grad_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            out_reg      <= out_next;
            grad_reg     <= grad_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        s_reg       <= s_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        t2_reg      <= t2_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_EXEC)
        else $error("input transfer did not start execution");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_reg <= 18'sd65536 && out_reg >= -18'sd65536)
        else $error("neuron output beyond +/- one");

    a_deriv_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRAD |-> d_reg <= 17'h10000)
        else $error("derivative beyond one");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && (!m_tvalid_reg || m_tready) |=> m_tvalid_reg && s_tready)
        else $error("result not presented on completion");

endmodule
